FILE: rtl/clr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package clr_pkg;

  // Fixed field widths
  localparam int unsigned COORD_IN_W = 16;
  localparam int unsigned LIMIT_W    = 13;
  localparam int unsigned PITCH_W    = 16;
  localparam int unsigned BPP_W      = 4;
  localparam int unsigned COLOR_W    = 32;
  localparam int unsigned OUT_XY_W   = 12;
  localparam int unsigned OFFSET_W   = 28;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Clamp arithmetic is done signed at this width (covers 2^16 and a 16-bit signed coordinate)
  localparam int unsigned CLAMP_W    = 18;

  // Request codes
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  // Register reset values
  localparam logic [LIMIT_W-1:0] FRAME_WIDTH_RST  = 13'd1024;
  localparam logic [LIMIT_W-1:0] FRAME_HEIGHT_RST = 13'd768;
  localparam logic [PITCH_W-1:0] ROW_PITCH_RST    = 16'd4096;
  localparam logic [BPP_W-1:0]   BPP_RST          = 4'd4;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH     = 3'd0,
    REG_FRAME_HEIGHT    = 3'd1,
    REG_ROW_PITCH_BYTES = 3'd2,
    REG_BYTES_PER_PIXEL = 3'd3
  } clr_reg_e;

  typedef struct packed {
    logic                         req_type;
    logic signed [COORD_IN_W-1:0] start_x;
    logic signed [COORD_IN_W-1:0] start_y;
    logic signed [COORD_IN_W-1:0] end_x;
    logic signed [COORD_IN_W-1:0] end_y;
    logic [COLOR_W-1:0]           color_in;
  } clr_in_t;

  typedef struct packed {
    logic                pixel_valid;
    logic [OUT_XY_W-1:0] pixel_x;
    logic [OUT_XY_W-1:0] pixel_y;
    logic [OFFSET_W-1:0] byte_offset;
    logic [COLOR_W-1:0]  pixel_color;
    logic                last_pixel;
  } clr_out_t;

endpackage

`default_nettype wire

FILE: rtl/clr_step.sv
`timescale 1ns / 1ps
`default_nettype none

module clr_step import clr_pkg::*; #(
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  adv,
  input  wire clr_in_t               req,
  input  wire logic [LIMIT_W-1:0]    frame_width,
  input  wire logic [LIMIT_W-1:0]    frame_height,
  output logic                       pix_valid,
  output logic [COORD_BITS-1:0]      pix_x,
  output logic [COORD_BITS-1:0]      pix_y,
  output logic [COLOR_W-1:0]         pix_color,
  output logic                       pix_last
);

  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned ERR_W = COORD_BITS + 2;
  localparam int unsigned CMP_W = COORD_BITS + 3;
  localparam logic signed [CLAMP_W-1:0] SPAN = CLAMP_W'(1) << COORD_BITS;

  // Clamp one signed coordinate into [0, limit-1], limit held to [1, 2^COORD_BITS]
  function automatic logic [CW-1:0] clamp_coord(input logic signed [COORD_IN_W-1:0] c,
                                                 input logic [LIMIT_W-1:0] lim_reg);
    logic signed [CLAMP_W-1:0] lim;
    logic signed [CLAMP_W-1:0] cw;
    logic signed [CLAMP_W-1:0] res;
    lim = $signed({{(CLAMP_W-LIMIT_W){1'b0}}, lim_reg});
    if (lim < CLAMP_W'(1)) begin
      lim = CLAMP_W'(1);
    end
    if (lim > SPAN) begin
      lim = SPAN;
    end
    cw = {{(CLAMP_W-COORD_IN_W){c[COORD_IN_W-1]}}, c};
    if (cw < 0) begin
      res = '0;
    end else if (cw >= lim) begin
      res = lim - CLAMP_W'(1);
    end else begin
      res = cw;
    end
    return res[CW-1:0];
  endfunction

  logic [CW-1:0]           cur_x_r, cur_y_r, tgt_x_r, tgt_y_r, dx_r, dy_r;
  logic [CW-1:0]           cur_x_nxt, cur_y_nxt, tgt_x_nxt, tgt_y_nxt, dx_nxt, dy_nxt;
  logic                    left_r, up_r, left_nxt, up_nxt;
  logic signed [ERR_W-1:0] err_r, err_nxt;
  logic [COLOR_W-1:0]      color_r, color_nxt;
  logic                    active_r;
  logic                    last_w;

  logic signed [CMP_W-1:0] err_w, twice, dx_s, dy_s, err_upd;

  // Work out the next pixel and line state for the item at the head
  always_comb begin
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    tgt_x_nxt = tgt_x_r;
    tgt_y_nxt = tgt_y_r;
    dx_nxt    = dx_r;
    dy_nxt    = dy_r;
    left_nxt  = left_r;
    up_nxt    = up_r;
    err_nxt   = err_r;
    color_nxt = color_r;
    err_w     = {err_r[ERR_W-1], err_r};
    twice     = err_w <<< 1;
    dx_s      = $signed({3'b000, dx_r});
    dy_s      = $signed({3'b000, dy_r});
    err_upd   = err_w;
    if (req.req_type == REQ_LOAD) begin
      cur_x_nxt = clamp_coord(req.start_x, frame_width);
      cur_y_nxt = clamp_coord(req.start_y, frame_height);
      tgt_x_nxt = clamp_coord(req.end_x, frame_width);
      tgt_y_nxt = clamp_coord(req.end_y, frame_height);
      color_nxt = req.color_in;
      left_nxt  = !(cur_x_nxt < tgt_x_nxt);
      up_nxt    = !(cur_y_nxt < tgt_y_nxt);
      dx_nxt    = left_nxt ? (cur_x_nxt - tgt_x_nxt) : (tgt_x_nxt - cur_x_nxt);
      dy_nxt    = up_nxt ? (cur_y_nxt - tgt_y_nxt) : (tgt_y_nxt - cur_y_nxt);
      err_nxt   = $signed({2'b00, dx_nxt}) - $signed({2'b00, dy_nxt});
    end else if (active_r) begin
      // Advance one Bresenham step
      if (twice > -dy_s) begin
        err_upd   = err_upd - dy_s;
        cur_x_nxt = left_r ? (cur_x_r - CW'(1)) : (cur_x_r + CW'(1));
      end
      if (twice < dx_s) begin
        err_upd   = err_upd + dx_s;
        cur_y_nxt = up_r ? (cur_y_r - CW'(1)) : (cur_y_r + CW'(1));
      end
      err_nxt = err_upd[ERR_W-1:0];
    end
  end

  assign last_w    = (cur_x_nxt == tgt_x_nxt) && (cur_y_nxt == tgt_y_nxt);
  assign pix_valid = (req.req_type == REQ_LOAD) || active_r;
  assign pix_x     = pix_valid ? cur_x_nxt : '0;
  assign pix_y     = pix_valid ? cur_y_nxt : '0;
  assign pix_color = pix_valid ? color_nxt : '0;
  assign pix_last  = pix_valid && last_w;

  // Commit line state when the item moves on; a step with no line leaves it alone
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r  <= '0;
      cur_y_r  <= '0;
      tgt_x_r  <= '0;
      tgt_y_r  <= '0;
      dx_r     <= '0;
      dy_r     <= '0;
      left_r   <= 1'b0;
      up_r     <= 1'b0;
      err_r    <= '0;
      color_r  <= '0;
      active_r <= 1'b0;
    end else if (adv && pix_valid) begin
      cur_x_r  <= cur_x_nxt;
      cur_y_r  <= cur_y_nxt;
      tgt_x_r  <= tgt_x_nxt;
      tgt_y_r  <= tgt_y_nxt;
      dx_r     <= dx_nxt;
      dy_r     <= dy_nxt;
      left_r   <= left_nxt;
      up_r     <= up_nxt;
      err_r    <= err_nxt;
      color_r  <= color_nxt;
      active_r <= !last_w;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/clr_offset.sv
`timescale 1ns / 1ps
`default_nettype none

module clr_offset import clr_pkg::*; #(
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic [COORD_BITS-1:0] pix_x,
  input  wire logic [COORD_BITS-1:0] pix_y,
  input  wire logic [PITCH_W-1:0]    row_pitch,
  input  wire logic [BPP_W-1:0]      bpp,
  output logic [OFFSET_W-1:0]        byte_offset
);

  localparam int unsigned FULL_W = COORD_BITS + PITCH_W + 1;

  logic [COORD_BITS+PITCH_W-1:0] row_part;
  logic [COORD_BITS+BPP_W-1:0]   col_part;
  logic [FULL_W-1:0]             full;
  logic [FULL_W+OFFSET_W-1:0]    full_ext;

  // y * pitch + x * bytes per pixel, wrapped to the offset width
  assign row_part    = pix_y * row_pitch;
  assign col_part    = pix_x * bpp;
  assign full        = FULL_W'(row_part) + FULL_W'(col_part);
  assign full_ext    = {{OFFSET_W{1'b0}}, full};
  assign byte_offset = full_ext[OFFSET_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/clamped_line_rasterizer.sv
`timescale 1ns / 1ps
`default_nettype none

// Bresenham line rasterizer with endpoint clamping. A load beat clamps both
// endpoints into the frame and returns the first pixel; each step beat returns
// the next pixel, and a step with no active line returns a beat with
// pixel_valid low. One result beat per input beat, one beat per clock
// sustained while out_ready is high; each beat passes the input, pixel and
// result registers. The rate is set by the error-term update in the step
// unit, whose line state feeds back into the next beat.
module clamped_line_rasterizer import clr_pkg::*; #(
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire clr_in_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output clr_out_t                   out_data,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [LIMIT_W-1:0] frame_width_r, frame_height_r;
  logic [PITCH_W-1:0] row_pitch_r;
  logic [BPP_W-1:0]   bpp_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      row_pitch_r    <= ROW_PITCH_RST;
      bpp_r          <= BPP_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:     frame_width_r  <= cfg_wdata[LIMIT_W-1:0];
        REG_FRAME_HEIGHT:    frame_height_r <= cfg_wdata[LIMIT_W-1:0];
        REG_ROW_PITCH_BYTES: row_pitch_r    <= cfg_wdata[PITCH_W-1:0];
        REG_BYTES_PER_PIXEL: bpp_r          <= cfg_wdata[BPP_W-1:0];
        default: ;
      endcase
    end
  end

  logic      s0_valid_r;
  clr_in_t   s0_data_r;
  logic      s1_valid_r;
  logic      s1_pix_valid_r;
  logic [COORD_BITS-1:0] s1_x_r, s1_y_r;
  logic [COLOR_W-1:0]    s1_color_r;
  logic      s1_last_r;
  logic      out_valid_r;
  clr_out_t  out_data_r;

  logic      adv0, adv1;
  logic      pix_valid, pix_last;
  logic [COORD_BITS-1:0] pix_x, pix_y;
  logic [COLOR_W-1:0]    pix_color;
  logic [OFFSET_W-1:0]   byte_offset;
  logic [COORD_BITS+OUT_XY_W-1:0] x_ext, y_ext;

  // Stage handshakes
  assign adv1     = s1_valid_r && (!out_valid_r || out_ready);
  assign adv0     = s0_valid_r && (!s1_valid_r || adv1);
  assign in_ready = !s0_valid_r || adv0;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_ready) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s0_data_r <= in_data;
    end
  end

  clr_step #(
    .COORD_BITS (COORD_BITS)
  ) u_step (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv0),
    .req          (s0_data_r),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .pix_valid    (pix_valid),
    .pix_x        (pix_x),
    .pix_y        (pix_y),
    .pix_color    (pix_color),
    .pix_last     (pix_last)
  );

  // Pixel register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!s1_valid_r || adv1) begin
      s1_valid_r <= adv0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv0) begin
      s1_pix_valid_r <= pix_valid;
      s1_x_r         <= pix_x;
      s1_y_r         <= pix_y;
      s1_color_r     <= pix_color;
      s1_last_r      <= pix_last;
    end
  end

  clr_offset #(
    .COORD_BITS (COORD_BITS)
  ) u_offset (
    .pix_x       (s1_x_r),
    .pix_y       (s1_y_r),
    .row_pitch   (row_pitch_r),
    .bpp         (bpp_r),
    .byte_offset (byte_offset)
  );

  assign x_ext = {{OUT_XY_W{1'b0}}, s1_x_r};
  assign y_ext = {{OUT_XY_W{1'b0}}, s1_y_r};

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      out_data_r.pixel_valid <= s1_pix_valid_r;
      out_data_r.pixel_x     <= x_ext[OUT_XY_W-1:0];
      out_data_r.pixel_y     <= y_ext[OUT_XY_W-1:0];
      out_data_r.byte_offset <= byte_offset;
      out_data_r.pixel_color <= s1_color_r;
      out_data_r.last_pixel  <= s1_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
